[rtl/mph_pkg.sv]
// Shared types, constants and letter helpers for the Metaphone encoder.
`timescale 1ns / 1ps
`default_nettype none

package mph_pkg;

  localparam int unsigned MPH_QUEUE_DEPTH = 4;
  localparam logic [7:0]  MPH_MAX_CODES_RST = 8'd4;

  // One classified beat handed from the front to the back.
  typedef struct packed {
    logic [7:0] letter;     // uppercase letter, valid when is_letter
    logic       is_letter;
    logic       word_end;
  } mph_item_t;

  function automatic logic ltr_is_vowel(input logic [7:0] c);
    return (c == "A") || (c == "E") || (c == "I") || (c == "O") || (c == "U");
  endfunction

  function automatic logic is_soft(input logic [7:0] c);
    return (c == "I") || (c == "E") || (c == "Y");
  endfunction

endpackage

`default_nettype wire

[rtl/metaphone_encoder_top.sv]
// Top level of the streaming Metaphone encoder.
`timescale 1ns / 1ps
`default_nettype none

// Streaming Metaphone coder. Each input beat carries one raw byte of a word
// (tuser high when the byte is present, tlast on the word's last beat).
// Non-letters are dropped and letters uppercased in the front end, which
// feeds a QUEUE_DEPTH-entry queue. The back end codes each letter once two
// letters after it are known and sends code letters, up to max_codes per
// word, then a terminator beat (tlast high, tuser high when the word
// produced no code). A letter first enters the three-letter window, then
// the rule runs on the oldest letter; an X adds a second code letter, and a
// word end drains the window and then sends the terminator. The output is
// registered, so the input keeps flowing while a result beat waits, until
// the window and queue fill. max_codes resets to 4 and must be written only
// while the coder is idle; the block itself does not enforce this.
module metaphone_encoder_top
  import mph_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = MPH_QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,      // max_codes
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,     // [7:0] char_byte
  input  wire logic       s_axis_tuser,     // [0] char_valid
  input  wire logic       s_axis_tlast,     // word_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,     // [7:0] code_letter
  output logic            m_axis_tuser,     // [0] is_null
  output logic            m_axis_tlast      // is_terminator
);

  logic [7:0] max_codes_q;
  mph_item_t  item, head;
  logic       push, full, pop, head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_codes_q <= MPH_MAX_CODES_RST;
    end else if (cfg_we_i) begin
      max_codes_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !full;

  mph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_byte_i  (s_axis_tdata),
    .char_valid_i (s_axis_tuser),
    .word_end_i   (s_axis_tlast),
    .beat_i       (s_axis_tvalid && !full),
    .item_o       (item),
    .push_o       (push)
  );

  mph_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (item),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (head_valid)
  );

  mph_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_codes_i  (max_codes_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_letter_o (m_axis_tdata),
    .out_term_o   (m_axis_tlast),
    .out_null_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

[rtl/mph_front.sv]
// Front end: filters raw bytes to uppercase letters and word ends.
`timescale 1ns / 1ps
`default_nettype none

module mph_front
  import mph_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic [7:0] char_byte_i,
  input  wire logic      char_valid_i,
  input  wire logic      word_end_i,
  input  wire logic      beat_i,      // input beat accepted this cycle
  output mph_item_t      item_o,
  output logic           push_o
);

  logic [7:0] upper;
  logic       letter_ok;

  always_comb begin
    upper = char_byte_i;
    if (char_byte_i >= "a" && char_byte_i <= "z") begin
      upper = char_byte_i - 8'd32;
    end
    letter_ok = char_valid_i && (upper >= "A") && (upper <= "Z");
  end

  assign item_o.letter    = upper;
  assign item_o.is_letter = letter_ok;
  assign item_o.word_end  = word_end_i;
  // Drop beats that carry neither a letter nor a word end.
  assign push_o = beat_i && (letter_ok || word_end_i);

  property p_push_needs_beat;
    @(posedge clk_i) disable iff (!rst_ni) push_o |-> beat_i;
  endproperty
  a_push_needs_beat: assert property (p_push_needs_beat)
    else $error("front pushed without an input beat");

  property p_letter_upper;
    @(posedge clk_i) disable iff (!rst_ni)
      item_o.is_letter |-> (item_o.letter >= "A" && item_o.letter <= "Z");
  endproperty
  a_letter_upper: assert property (p_letter_upper)
    else $error("front passed a non-uppercase letter");

  property p_end_kept;
    @(posedge clk_i) disable iff (!rst_ni) (beat_i && word_end_i) |-> push_o;
  endproperty
  a_end_kept: assert property (p_end_kept)
    else $error("front dropped a word end");

endmodule

`default_nettype wire

[rtl/mph_queue.sv]
// Small queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mph_queue
  import mph_pkg::*;
#(
  parameter int unsigned DEPTH = MPH_QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  mph_item_t push_item_i,
  output logic      full_o,
  input  wire logic pop_i,
  output mph_item_t head_o,
  output logic      valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  mph_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt;
  endproperty
  a_cnt_bound: assert property (p_cnt_bound)
    else $error("queue count beyond depth");

  property p_ptr_gap;
    @(posedge clk_i) disable iff (!rst_ni)
      (cnt_q == '0 || cnt_q == FullCnt) |-> (wr_ptr_q == rd_ptr_q);
  endproperty
  a_ptr_gap: assert property (p_ptr_gap)
    else $error("queue pointers disagree with count");

  property p_full_no_grow;
    @(posedge clk_i) disable iff (!rst_ni) (full_o && !pop_i) |=> full_o;
  endproperty
  a_full_no_grow: assert property (p_full_no_grow)
    else $error("queue left full state without a pop");

endmodule

`default_nettype wire

[rtl/mph_back.sv]
// Back end: letter window, Metaphone rules, code cap and output register.
`timescale 1ns / 1ps
`default_nettype none

module mph_back
  import mph_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] max_codes_i,
  input  mph_item_t       head_i,
  input  wire logic       head_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_letter_o,
  output logic            out_term_o,
  output logic            out_null_o
);

  logic [7:0] prev_q, prev_d;
  logic [7:0] win_q [3];
  logic [7:0] win_d [3];
  logic [1:0] fill_q, fill_d;
  logic [1:0] skip_q, skip_d;
  logic [7:0] codes_q, codes_d;
  logic       flush_q, flush_d;
  logic       pend_s_q, pend_s_d;

  logic       ov_q, ov_d;
  logic [7:0] ol_q, ol_d;
  logic       ot_q, ot_d, on_q, on_d;

  logic       out_free;
  logic       load;
  logic [7:0] load_letter;
  logic       load_term, load_null;

  // Rule decode for the oldest window letter.
  logic [7:0] c, a1, a2, p, cc;
  logic       first, init_drop, repeat_skip;
  logic       e_en, x_two;
  logic [7:0] e_letter;
  logic [1:0] new_skip;
  logic       k_ok, s_ok;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    c  = win_q[0];
    a1 = win_q[1];
    a2 = win_q[2];
    p  = prev_q;
    first = (prev_q == 8'd0);
    init_drop = first && (((c == "A") && (a1 == "E")) || ((c == "G") && (a1 == "N")) ||
                          ((c == "K") && (a1 == "N")) || ((c == "P") && (a1 == "N")) ||
                          ((c == "W") && (a1 == "R")));
    cc = (first && (c == "X")) ? "S" : c;
    repeat_skip = (cc != "C") && !first && (cc == p);
    e_en     = 1'b0;
    e_letter = cc;
    x_two    = 1'b0;
    new_skip = 2'd0;
    unique case (cc) inside
      "A", "E", "I", "O", "U": e_en = first;
      "B": e_en = !(!first && (p == "M") && (a1 == 8'd0));
      "C": begin
        e_en = 1'b1;
        if ((a1 == "I") && (a2 == "A")) begin
          e_letter = "X";
        end else if (a1 == "H") begin
          e_letter = "X";
          new_skip = 2'd1;
        end else if (is_soft(a1)) begin
          e_letter = "S";
        end else begin
          e_letter = "K";
        end
      end
      "D": begin
        e_en = 1'b1;
        e_letter = ((a1 == "G") && is_soft(a2)) ? "J" : "T";
      end
      "G": begin
        if ((a1 == "H") && (a2 != 8'd0) && !ltr_is_vowel(a2)) begin
          e_en = 1'b0;
        end else if (!first && (a1 == "H") && (a2 == 8'd0)) begin
          e_en = 1'b0;
        end else if (!first && (a1 == 8'd0) && (p == "G")) begin
          e_en = 1'b0;
        end else begin
          e_en = 1'b1;
          if (is_soft(a1)) begin
            e_letter = (!first && (p == "G")) ? "K" : "J";
          end else begin
            e_letter = "K";
          end
        end
      end
      "H": e_en = ltr_is_vowel(a1) && (first || !ltr_is_vowel(p));
      "K": e_en = first || (p != "C");
      "P": begin
        e_en = 1'b1;
        if (a1 == "H") begin
          e_letter = "F";
          new_skip = 2'd1;
        end
      end
      "Q": begin
        e_en = 1'b1;
        e_letter = "K";
      end
      "S": begin
        e_en = 1'b1;
        if (a1 == "H") begin
          e_letter = "X";
          new_skip = 2'd1;
        end else if ((a1 == "I") && ((a2 == "O") || (a2 == "A"))) begin
          e_letter = "X";
          new_skip = 2'd2;
        end
      end
      "T": begin
        e_en = 1'b1;
        if ((a1 == "I") && ((a2 == "A") || (a2 == "O"))) begin
          e_letter = "X";
        end else if (a1 == "H") begin
          e_letter = "0";
          new_skip = 2'd1;
        end
      end
      "V": begin
        e_en = 1'b1;
        e_letter = "F";
      end
      "W", "Y": e_en = ltr_is_vowel(a1);
      "X": begin
        e_en = 1'b1;
        e_letter = "K";
        x_two = 1'b1;
      end
      "Z": begin
        e_en = 1'b1;
        e_letter = "S";
      end
      "F", "J", "L", "M", "N", "R": e_en = 1'b1;
      default: e_en = 1'b0;
    endcase
    k_ok = (codes_q < max_codes_i);
    s_ok = ({1'b0, codes_q} + 9'd1) < {1'b0, max_codes_i};
  end

  always_comb begin
    prev_d   = prev_q;
    win_d    = win_q;
    fill_d   = fill_q;
    skip_d   = skip_q;
    codes_d  = codes_q;
    flush_d  = flush_q;
    pend_s_d = pend_s_q;
    pop_o    = 1'b0;
    load        = 1'b0;
    load_letter = 8'd0;
    load_term   = 1'b0;
    load_null   = 1'b0;

    if (pend_s_q) begin
      // Second half of KS from an X.
      if (out_free) begin
        load        = 1'b1;
        load_letter = "S";
        codes_d     = codes_q + 8'd1;
        pend_s_d    = 1'b0;
      end
    end else if ((fill_q == 2'd3) || (flush_q && (fill_q != 2'd0))) begin
      if (out_free) begin
        win_d[0] = a1;
        win_d[1] = a2;
        win_d[2] = 8'd0;
        fill_d   = fill_q - 2'd1;
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
          prev_d = c;
        end else if (init_drop) begin
          prev_d = c;
        end else begin
          prev_d = cc;
          if (!repeat_skip) begin
            skip_d = new_skip;
            if (e_en && k_ok) begin
              load        = 1'b1;
              load_letter = e_letter;
              codes_d     = codes_q + 8'd1;
            end
            if (x_two && s_ok) begin
              pend_s_d = 1'b1;
            end
          end
        end
      end
    end else if (flush_q) begin
      if (out_free) begin
        load      = 1'b1;
        load_term = 1'b1;
        load_null = (codes_q == 8'd0);
        prev_d    = 8'd0;
        win_d[0]  = 8'd0;
        win_d[1]  = 8'd0;
        win_d[2]  = 8'd0;
        fill_d    = 2'd0;
        skip_d    = 2'd0;
        codes_d   = 8'd0;
        flush_d   = 1'b0;
      end
    end else if (head_valid_i) begin
      pop_o = 1'b1;
      if (head_i.is_letter) begin
        case (fill_q)
          2'd0:    win_d[0] = head_i.letter;
          2'd1:    win_d[1] = head_i.letter;
          default: win_d[2] = head_i.letter;
        endcase
        fill_d = fill_q + 2'd1;
      end
      flush_d = head_i.word_end;
    end

    ov_d = ov_q;
    ol_d = ol_q;
    ot_d = ot_q;
    on_d = on_q;
    if (load) begin
      ov_d = 1'b1;
      ol_d = load_letter;
      ot_d = load_term;
      on_d = load_null;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 8'd0;
      win_q[0] <= 8'd0;
      win_q[1] <= 8'd0;
      win_q[2] <= 8'd0;
      fill_q   <= 2'd0;
      skip_q   <= 2'd0;
      codes_q  <= 8'd0;
      flush_q  <= 1'b0;
      pend_s_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      prev_q   <= prev_d;
      win_q    <= win_d;
      fill_q   <= fill_d;
      skip_q   <= skip_d;
      codes_q  <= codes_d;
      flush_q  <= flush_d;
      pend_s_q <= pend_s_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ol_q <= ol_d;
    ot_q <= ot_d;
    on_q <= on_d;
  end

  assign out_valid_o  = ov_q;
  assign out_letter_o = ol_q;
  assign out_term_o   = ot_q;
  assign out_null_o   = on_q;

  property p_pend_after_k;
    @(posedge clk_i) disable iff (!rst_ni) pend_s_q |-> ov_q;
  endproperty
  a_pend_after_k: assert property (p_pend_after_k)
    else $error("pending S without a K beat ahead of it");

  property p_skip_in_window;
    @(posedge clk_i) disable iff (!rst_ni) skip_q <= fill_q;
  endproperty
  a_skip_in_window: assert property (p_skip_in_window)
    else $error("skip count exceeds buffered letters");

  property p_term_follows_flush;
    @(posedge clk_i) disable iff (!rst_ni)
      (flush_q && (fill_q == 2'd0) && !pend_s_q && out_free) |=> (ov_q && ot_q);
  endproperty
  a_term_follows_flush: assert property (p_term_follows_flush)
    else $error("drained word did not produce a terminator");

  property p_no_pop_while_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      pop_o |-> (!flush_q && (fill_q != 2'd3) && !pend_s_q);
  endproperty
  a_no_pop_while_busy: assert property (p_no_pop_while_busy)
    else $error("item taken while previous work was open");

endmodule

`default_nettype wire
